// ===== hdl/integer_matrix_multiply_core_assert.svh =====
// assertion macros for the integer matrix multiply core
// expects clk and arst_n in the scope of the including module
`ifndef INTEGER_MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_CORE_ASSERT_SVH

// property checked on every clock edge outside reset
`define IMM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define IMM_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hdl/imm_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants of the integer matrix multiply core
// no dependencies
package imm_pkg;

	localparam int DIM_DEFAULT = 16;
	localparam int MAX_EXT = 16;
	localparam int REG_W = 5;
	localparam int CFG_IW = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [REG_W-1:0] REG_RESET = REG_W'(16);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STREAM = 1'b1
	} op_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_ROWS_A = 2'd0,
		CFG_INNER_LEN = 2'd1,
		CFG_COLS_B = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ISSUE,
		BK_DRAIN,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		op_t op;
		logic [3:0] row_index;
		logic [3:0] col_index;
		logic signed [31:0] elem_value;
	} in_item_t;

	typedef struct packed {
		logic [3:0] out_row;
		logic [3:0] out_col;
		logic signed [31:0] product_sum;
		logic row_done;
		logic matrix_done;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		op_t kind;
		logic first;
		logic last;
		logic row_last;
		logic [3:0] row;
		logic [3:0] col;
		logic [31:0] value;
	} job_t;

	// zero acts as one, anything above the cap acts as the cap
	function automatic logic [REG_W-1:0] eff_size(input logic [REG_W-1:0] v,
			input logic [REG_W-1:0] cap);
		logic [REG_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = REG_W'(1);
		end else if (v > cap) begin
			r = cap;
		end
		return r;
	endfunction

endpackage

// ===== hdl/imm_front.sv =====
`timescale 1ns / 1ps
// front end: configuration registers, item acceptance and classification
// depends on imm_pkg
module imm_front #(
	parameter int DIM = imm_pkg::DIM_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  imm_pkg::in_item_t req_item,
	input  logic cfg_we,
	input  logic [imm_pkg::CFG_IW-1:0] cfg_index,
	input  logic [imm_pkg::REG_W-1:0] cfg_data,
	input  logic q_full,
	output logic push,
	output imm_pkg::job_t push_item,
	output logic [imm_pkg::REG_W-1:0] cols_eff
);
	import imm_pkg::*;

	localparam logic [REG_W-1:0] CAP = REG_W'((DIM < MAX_EXT) ? DIM : MAX_EXT);

	logic [REG_W-1:0] rows_q, inner_q, cols_q;
	logic [REG_W-1:0] nr, nk;
	logic accept, load_ok, stream_ok;
	logic [REG_W-1:0] row_w, col_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= REG_RESET;
			inner_q <= REG_RESET;
			cols_q <= REG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS_A: rows_q <= cfg_data;
				CFG_INNER_LEN: inner_q <= cfg_data;
				CFG_COLS_B: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign nr = eff_size(rows_q, CAP);
	assign nk = eff_size(inner_q, CAP);
	assign cols_eff = eff_size(cols_q, CAP);

	assign req_stall = q_full;
	assign accept = req_valid && !req_stall;

	assign row_w = REG_W'(req_item.row_index);
	assign col_w = REG_W'(req_item.col_index);

	// loads beyond the store are dropped, stream items outside the sizes too
	assign load_ok = (32'(req_item.row_index) < 32'(DIM))
		&& (32'(req_item.col_index) < 32'(DIM));
	assign stream_ok = (row_w < nr) && (col_w < nk);

	always_comb begin
		push = 1'b0;
		if (accept) begin
			case (req_item.op)
				OP_LOAD: push = load_ok;
				OP_STREAM: push = stream_ok;
				default: push = 1'b0;
			endcase
		end
		push_item.kind = req_item.op;
		push_item.first = (req_item.col_index == '0);
		push_item.last = (col_w == nk - REG_W'(1));
		push_item.row_last = (row_w == nr - REG_W'(1));
		push_item.row = req_item.row_index;
		push_item.col = req_item.col_index;
		push_item.value = req_item.elem_value;
	end

endmodule

// ===== hdl/imm_queue.sv =====
`timescale 1ns / 1ps
// short item queue between front and back end
// depends on imm_pkg
module imm_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  imm_pkg::job_t push_item,
	output logic full,
	output logic pop_valid,
	input  logic pop,
	output imm_pkg::job_t pop_item
);
	import imm_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

	job_t slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_SLOT) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_SLOT) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_item;
		end
	end

endmodule

// ===== hdl/imm_back.sv =====
`timescale 1ns / 1ps
// back end: B store, column multiply-accumulate pipeline and result output
// depends on imm_pkg and integer_matrix_multiply_core_assert.svh
`include "integer_matrix_multiply_core_assert.svh"
module imm_back #(
	parameter int DIM = imm_pkg::DIM_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  imm_pkg::job_t q_item,
	output logic q_pop,
	input  logic [imm_pkg::REG_W-1:0] cols_eff,
	output logic rsp_valid,
	input  logic rsp_stall,
	output imm_pkg::out_item_t rsp_item
);
	import imm_pkg::*;

	localparam int ACC_N = (DIM < MAX_EXT) ? DIM : MAX_EXT;
	localparam int JW = $clog2(ACC_N);
	localparam int IW = $clog2(DIM);

	logic [31:0] bmem [DIM][DIM];
	logic [31:0] acc_q [ACC_N];

	back_state_t state_q, state_d;
	job_t cur_q;
	logic [JW-1:0] j_q;

	logic v_s1, first_s1;
	logic [JW-1:0] j_s1;
	logic [31:0] a_s1, b_s1;
	logic v_s2, first_s2;
	logic [JW-1:0] j_s2;
	logic [31:0] prod_s2;

	logic [31:0] mult_lo, acc_rd;
	logic [JW-1:0] acc_raddr;
	logic j_last, settled, issue, load_wr, start, out_load;

	out_item_t rsp_q;
	logic rsp_valid_q;

	assign j_last = (REG_W'(j_q) == cols_eff - REG_W'(1));
	assign settled = !v_s1 && !v_s2;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && q_item.kind == OP_STREAM) state_d = BK_ISSUE;
			end
			BK_ISSUE: begin
				if (j_last) state_d = BK_DRAIN;
			end
			BK_DRAIN: begin
				if (settled) state_d = cur_q.last ? BK_EMIT : BK_IDLE;
			end
			BK_EMIT: begin
				if (out_load && j_last) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		load_wr = 1'b0;
		start = 1'b0;
		issue = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_pop = q_valid;
				load_wr = q_valid && (q_item.kind == OP_LOAD);
				start = q_valid && (q_item.kind == OP_STREAM);
			end
			BK_ISSUE: issue = 1'b1;
			BK_DRAIN: ;
			BK_EMIT: out_load = !rsp_valid_q || !rsp_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			j_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				j_q <= '0;
			end else if (issue || out_load) begin
				j_q <= j_last ? '0 : j_q + JW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// b store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (load_wr) begin
			bmem[IW'(q_item.row)][IW'(q_item.col)] <= q_item.value;
		end
		if (issue) begin
			b_s1 <= bmem[IW'(cur_q.col)][IW'(j_q)];
		end
	end

	assign mult_lo = a_s1 * b_s1;

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= q_item;
		end
		j_s1 <= j_q;
		first_s1 <= cur_q.first;
		a_s1 <= cur_q.value;
		j_s2 <= j_s1;
		first_s2 <= first_s1;
		prod_s2 <= mult_lo;
	end

	assign acc_raddr = (state_q == BK_EMIT) ? j_q : j_s2;
	assign acc_rd = acc_q[acc_raddr];

	// first inner index clears the whole row in the same cycle that its first column lands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ACC_N; i++) begin
				acc_q[i] <= '0;
			end
		end else if (v_s2) begin
			if (first_s2 && j_s2 == '0) begin
				for (int i = 0; i < ACC_N; i++) begin
					acc_q[i] <= '0;
				end
				acc_q[0] <= prod_s2;
			end else begin
				acc_q[j_s2] <= acc_rd + prod_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q.out_row <= cur_q.row;
			rsp_q.out_col <= 4'(j_q);
			rsp_q.product_sum <= acc_rd;
			rsp_q.row_done <= j_last;
			rsp_q.matrix_done <= j_last && cur_q.row_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item = rsp_q;

	`IMM_ASSERT(a_pipe_busy_in_mac, v_s2 |-> (state_q == BK_ISSUE || state_q == BK_DRAIN), "mac pipeline active outside multiply phase")
	`IMM_ASSERT(a_emit_settled, (state_q == BK_EMIT) |-> settled, "emitting while accumulators still updating")
	`IMM_ASSERT_NEXT(a_matrix_done_row, out_load && j_last && cur_q.row_last, rsp_valid && rsp_item.row_done && rsp_item.matrix_done, "matrix end not flagged with row end")

endmodule

// ===== hdl/integer_matrix_multiply_core.sv =====
`timescale 1ns / 1ps
// integer matrix multiply core, top level
// depends on imm_pkg, imm_front, imm_queue, imm_back
//
// Computes C = A * B with 32-bit wrapping sums. Load items write one element of B into
// a DIM x DIM store; stream items carry one element of A, and the element at the last
// inner index emits that row's cols_b results in column order. The front end accepts
// one item per cycle, unless stalled, into a two-entry queue. The back end writes a
// load item to the B store as it leaves the queue; a stream item leaves the queue,
// reads one B element per column through the store's single read port and waits for
// the multiply and accumulate stages to settle; the last element of a row then sends
// the results, holding while the output is stalled. A stream item blocks the queue
// until done. A zero size register acts as one and sizes above min(16, DIM) are capped.
module integer_matrix_multiply_core #(
	parameter int DIM = imm_pkg::DIM_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  imm_pkg::in_item_t req_item,
	output logic rsp_valid,
	input  logic rsp_stall,
	output imm_pkg::out_item_t rsp_item,
	input  logic cfg_we,
	input  logic [imm_pkg::CFG_IW-1:0] cfg_index,
	input  logic [imm_pkg::REG_W-1:0] cfg_data
);
	import imm_pkg::*;

	logic q_full, push, q_valid, q_pop;
	job_t push_item, q_item;
	logic [REG_W-1:0] cols_eff;

	imm_front #(
		.DIM(DIM)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item(req_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_full(q_full),
		.push(push),
		.push_item(push_item),
		.cols_eff(cols_eff)
	);

	imm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(q_full),
		.pop_valid(q_valid),
		.pop(q_pop),
		.pop_item(q_item)
	);

	imm_back #(
		.DIM(DIM)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.cols_eff(cols_eff),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item(rsp_item)
	);

endmodule
